// ===== sv/page_framebuffer_blit_engine_macros.svh =====
// Assertion macros for the blit engine checker
`ifndef PAGE_FRAMEBUFFER_BLIT_ENGINE_MACROS_SVH
`define PAGE_FRAMEBUFFER_BLIT_ENGINE_MACROS_SVH
// Implication checked on every clock edge outside reset
`define PFB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset
`define PFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== sv/pfb_pkg.sv =====
package pfb_pkg;
   localparam int SCREEN_COLUMNS_DEFAULT = 128;
   localparam int SCREEN_ROWS_DEFAULT    = 64;

   localparam logic [2:0] ACT_START = 3'd0;
   localparam logic [2:0] ACT_BYTE  = 3'd1;
   localparam logic [2:0] ACT_CLEAR = 3'd2;
   localparam logic [2:0] ACT_CLALL = 3'd3;
   localparam logic [2:0] ACT_READ  = 3'd4;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_CLRRD, ST_CLEAR, ST_RD1, ST_WR1, ST_RD2, ST_WR2, ST_RDB,
      ST_RDB2, ST_OUT
   } pfb_state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;   // latch request fields, set up operation
      logic clr_rd;    // read the byte at the clear walk position
      logic clr_step;  // write back one cleared byte and advance the walk
      logic rd_main;   // read primary byte address
      logic wr_main;   // write primary byte
      logic rd_spill;  // read spill byte address
      logic wr_spill;  // write spill byte
      logic rd_user;   // read byte for a read request
      logic finish;    // latch response
   } pfb_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_clear;  // request clears a rectangle or the whole store
      logic is_put;    // request writes a byte
      logic has_spill; // byte has a spill into next page
      logic is_read;   // request reads a byte
      logic clr_last;  // last byte of the clear walk
      logic clr_all;   // clear walk zeroes whole bytes, no read needed
   } pfb_stat_type;
endpackage

// ===== sv/pfb_if.sv =====
interface pfb_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] left_column;
   logic [7:0] top_row;
   logic [7:0] rect_width;
   logic [7:0] rect_height;
   logic [7:0] image_byte;
   logic [2:0] read_page;
   logic [6:0] read_column;
   modport source (output valid, action, left_column, top_row, rect_width, rect_height,
                   image_byte, read_page, read_column, input ready);
   modport sink (input valid, action, left_column, top_row, rect_width, rect_height,
                 image_byte, read_page, read_column, output ready);
endinterface

interface pfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       ignored;
   modport source (output valid, read_data, ignored, input ready);
   modport sink (input valid, read_data, ignored, output ready);
endinterface

// ===== sv/pfb_ctrl.sv =====
module pfb_ctrl import pfb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_fire,
   input  logic         rsp_busy,
   input  pfb_stat_type stat,
   output pfb_cmd_type  cmd,
   output logic         idle
);
   pfb_state_type state_ff, state_in;

   // Advance state; reset starts the store clearing pass
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_INIT;
      else       state_ff <= state_in;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: if (stat.clr_last) state_in = ST_IDLE;
         ST_IDLE: if (req_fire) state_in = ST_RD1;
         ST_RD1: begin
            if (stat.is_clear)     state_in = stat.clr_all ? ST_CLEAR : ST_CLRRD;
            else if (stat.is_put)  state_in = ST_RDB;
            else if (stat.is_read) state_in = ST_RDB;
            else                   state_in = ST_OUT;
         end
         ST_CLRRD: state_in = ST_CLEAR;
         ST_CLEAR: begin
            if (stat.clr_last)     state_in = ST_OUT;
            else if (!stat.clr_all) state_in = ST_CLRRD;
         end
         ST_RDB:  state_in = stat.is_read ? ST_RDB2 : ST_WR1;
         ST_RDB2: state_in = ST_OUT;
         ST_WR1:  state_in = stat.has_spill ? ST_RD2 : ST_OUT;
         ST_RD2:  state_in = ST_WR2;
         ST_WR2:  state_in = ST_OUT;
         ST_OUT:  if (!rsp_busy) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_INIT:  cmd.clr_step = 1'b1;
         ST_IDLE:  cmd.capture  = req_fire;
         ST_RD1:   begin
            cmd.rd_main = stat.is_put;
            cmd.rd_user = stat.is_read;
         end
         ST_CLRRD: cmd.clr_rd   = 1'b1;
         ST_CLEAR: cmd.clr_step = 1'b1;
         ST_RDB:   cmd.wr_main  = stat.is_put;
         ST_WR1:   cmd.rd_spill = stat.has_spill;
         ST_RD2:   cmd.wr_spill = 1'b1;
         ST_OUT:   cmd.finish   = !rsp_busy;
         default:  cmd = '0;
      endcase
   end

   assign idle = (state_ff == ST_IDLE);
endmodule

// ===== sv/pfb_dpath.sv =====
module pfb_dpath import pfb_pkg::*; #(
   parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEFAULT,
   parameter int SCREEN_ROWS    = SCREEN_ROWS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [2:0]   action,
   input  logic [7:0]   left_column,
   input  logic [7:0]   top_row,
   input  logic [7:0]   rect_width,
   input  logic [7:0]   rect_height,
   input  logic [7:0]   image_byte,
   input  logic [2:0]   read_page,
   input  logic [6:0]   read_column,
   input  pfb_cmd_type  cmd,
   output pfb_stat_type stat,
   output logic [7:0]   rsp_data,
   output logic         rsp_ignored
);
   localparam int PAGES = (SCREEN_ROWS + 7) / 8;
   localparam int PW    = $clog2(PAGES) > 0 ? $clog2(PAGES) : 1;
   localparam int CW    = $clog2(SCREEN_COLUMNS);
   localparam int AW    = PW + CW;
   localparam int DEPTH = 2 ** AW;
   localparam logic [8:0] COLS9 = 9'(SCREEN_COLUMNS);
   localparam logic [8:0] ROWS9 = 9'(SCREEN_ROWS);
   localparam logic [PW:0] PAGES_N = (PW + 1)'(PAGES);

   logic [7:0] mem [DEPTH];
   logic [7:0] mem_q;

   logic [2:0] act_ff;
   logic [7:0] x_ff, y_ff, b_ff;
   logic [8:0] ex_ff, ey_ff;
   logic [8:0] cx_ff;
   logic [5:0] cp_ff, ep_ff;
   logic       all_ff;
   logic [2:0] rp_ff;
   logic [6:0] rc_ff;
   logic       ign_ff;
   logic [7:0] data_ff;

   // Armed blit state
   logic [7:0]  bx_ff, by_ff, bfw_ff, bvw_ff, bcol_ff;
   logic [4:0]  bbands_ff, bband_ff;
   logic        armed_ff;

   logic geo_ok;
   assign geo_ok = ({1'b0, left_column} < COLS9) && ({1'b0, top_row} < ROWS9)
                   && rect_width != 8'd0 && rect_height != 8'd0;

   logic [8:0] ex_c, ey_c;
   always_comb begin
      ex_c = 9'(left_column) + 9'(rect_width);
      if (ex_c > COLS9) ex_c = COLS9;
      ey_c = 9'(top_row) + 9'(rect_height);
      if (ey_c > ROWS9) ey_c = ROWS9;
   end

   // Put-byte addressing
   logic [5:0]  page_c;
   logic [8:0]  pcx_c;
   logic        put_ok;
   logic [2:0]  sh;
   logic        spill_ok;
   always_comb begin
      sh      = by_ff[2:0];
      page_c  = 6'(by_ff[7:3]) + 6'(bband_ff);
      pcx_c   = 9'(bx_ff) + 9'(bcol_ff);
      put_ok  = armed_ff && bband_ff < bbands_ff && bcol_ff < bvw_ff &&
                page_c < 6'(PAGES_N) && pcx_c < COLS9;
      spill_ok = put_ok && sh != 3'd0 && (page_c + 6'd1) < 6'(PAGES_N);
   end

   // Rows of the current clear page that fall inside the rectangle
   logic [7:0] clr_mask;
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         clr_mask[i] = ({cp_ff, 3'(i)} >= {1'b0, y_ff}) && ({cp_ff, 3'(i)} < ey_ff);
      end
   end

   logic [AW-1:0] addr_c;
   logic [AW-1:0] main_a, spill_a, clr_a, rd_a;
   assign main_a  = {page_c[PW-1:0], pcx_c[CW-1:0]};
   assign spill_a = {PW'(page_c + 6'd1), pcx_c[CW-1:0]};
   assign clr_a   = {cp_ff[PW-1:0], cx_ff[CW-1:0]};
   assign rd_a    = {PW'(rp_ff), CW'(rc_ff)};

   logic is_clear_c, is_put_c, is_read_c, rd_in_range;
   assign rd_in_range = ({3'b0, rp_ff} < 6'(PAGES_N)) && ({2'b0, rc_ff} < COLS9);
   assign is_clear_c = act_ff == ACT_CLALL ||
                       ((act_ff == ACT_START || act_ff == ACT_CLEAR) && !ign_ff);
   assign is_put_c  = act_ff == ACT_BYTE && put_ok;
   assign is_read_c = act_ff == ACT_READ && rd_in_range;
   assign stat.is_clear  = is_clear_c;
   assign stat.is_put    = is_put_c;
   assign stat.is_read   = is_read_c;
   assign stat.has_spill = spill_ok;
   assign stat.clr_last  = (cx_ff + 9'd1 >= ex_ff) && (cp_ff + 6'd1 >= ep_ff);
   assign stat.clr_all   = all_ff;

   always_comb begin
      priority if (cmd.wr_spill || cmd.rd_spill) addr_c = spill_a;
      else if (cmd.rd_user)                       addr_c = rd_a;
      else if (cmd.clr_rd || cmd.clr_step)        addr_c = clr_a;
      else                                        addr_c = main_a;
   end

   logic [7:0] wdata;
   always_comb begin
      priority if (cmd.clr_step) wdata = all_ff ? 8'd0 : (mem_q & ~clr_mask);
      else if (cmd.wr_spill)     wdata = mem_q | (b_ff >> (4'd8 - 4'(sh)));
      else                       wdata = mem_q | (b_ff << sh);
   end

   // Store: one port, registered read
   always_ff @(posedge clock) begin
      if (cmd.rd_main || cmd.rd_spill || cmd.rd_user || cmd.clr_rd) mem_q <= mem[addr_c];
      if (cmd.wr_main || cmd.wr_spill || cmd.clr_step) mem[addr_c] <= wdata;
   end

   // Capture request, walk clear area page by page, column by column
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0; ex_ff <= COLS9; ep_ff <= 6'(PAGES);
         cx_ff <= '0; cp_ff <= '0; all_ff <= 1'b1;
      end else if (cmd.capture) begin
         act_ff <= action;
         x_ff <= left_column; y_ff <= top_row; b_ff <= image_byte;
         rp_ff <= read_page; rc_ff <= read_column;
         ign_ff <= 1'b0;
         ex_ff <= ex_c; ey_ff <= ey_c;
         ep_ff <= 6'((ey_c - 9'd1) >> 3) + 6'd1;
         cx_ff <= 9'(left_column); cp_ff <= 6'(top_row[7:3]);
         all_ff <= 1'b0;
         if ((action == ACT_START || action == ACT_CLEAR) && !geo_ok) ign_ff <= 1'b1;
         if (action > ACT_READ) ign_ff <= 1'b1;
         if (action == ACT_CLALL) begin
            x_ff <= '0; ex_ff <= COLS9; ep_ff <= 6'(PAGES);
            cx_ff <= '0; cp_ff <= '0; all_ff <= 1'b1;
         end
      end else if (cmd.clr_step) begin
         if (cx_ff + 9'd1 >= ex_ff) begin
            cx_ff <= 9'(x_ff);
            cp_ff <= cp_ff + 6'd1;
         end else begin
            cx_ff <= cx_ff + 9'd1;
         end
      end
   end

   // Blit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         bx_ff <= '0; by_ff <= '0; bfw_ff <= '0; bvw_ff <= '0;
         bbands_ff <= '0; bband_ff <= '0; bcol_ff <= '0;
      end else if (cmd.capture && action == ACT_START) begin
         if (geo_ok) begin
            bx_ff <= left_column; by_ff <= top_row; bfw_ff <= rect_width;
            bvw_ff <= 8'(ex_c - 9'(left_column));
            bbands_ff <= 5'((ey_c - 9'(top_row) - 9'd1) >> 3) + 5'd1;
            bcol_ff <= '0; bband_ff <= '0;
            armed_ff <= 1'b1;
         end else begin
            armed_ff <= 1'b0;
         end
      end else if (cmd.finish && act_ff == ACT_BYTE && armed_ff) begin
         if (9'(bcol_ff) + 9'd1 >= 9'(bfw_ff)) begin
            bcol_ff  <= '0;
            bband_ff <= bband_ff + 5'd1;
            if (bband_ff + 5'd1 >= bbands_ff) armed_ff <= 1'b0;
         end else begin
            bcol_ff <= bcol_ff + 8'd1;
         end
      end
   end

   // Latch response
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         data_ff <= is_read_c ? mem_q : 8'd0;
         rsp_ignored <= ign_ff || (act_ff == ACT_BYTE && !put_ok);
      end
   end
   assign rsp_data = data_ff;
endmodule

// ===== sv/page_framebuffer_blit_engine.sv =====
// Monochrome page framebuffer blit engine: a one-bit display store (128x64 by
// default) kept as pages of eight rows, one byte per column, served one request at
// a time with one response each. After reset the store is cleared by a pass that
// writes one byte per cycle (pages x columns bytes, 1024 by default) while the
// request side is held off. A rejected or unknown request or a dropped image byte
// goes straight to its response; a read fetches its byte, and an image byte is
// merged into its byte and, with spill, into the byte of the next page (each byte
// is a read-modify-write of the single port store). A clear area or a valid start
// blit reads each byte of the clipped rectangle, then writes it back with its rows
// masked off; clear all writes zero to every byte with no read. The next request
// can be accepted in the same cycle as the response is raised. The response is
// held in an output register until taken; the next request may run meanwhile but
// does not complete before it.
module page_framebuffer_blit_engine import pfb_pkg::*; #(
   parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEFAULT,
   parameter int SCREEN_ROWS    = SCREEN_ROWS_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   pfb_req_if.sink   req,
   pfb_rsp_if.source rsp
);
   pfb_cmd_type  cmd;
   pfb_stat_type stat;
   logic idle, rsp_valid_ff, req_fire, rsp_busy;
   logic [7:0] data;
   logic ign;

   assign req.ready = idle;
   assign req_fire  = req.valid && req.ready;
   assign rsp_busy  = rsp_valid_ff && !rsp.ready;

   pfb_ctrl u_ctrl (.clock, .reset, .req_fire, .rsp_busy,
                    .stat, .cmd, .idle);

   pfb_dpath #(.SCREEN_COLUMNS(SCREEN_COLUMNS), .SCREEN_ROWS(SCREEN_ROWS)) u_dpath (
      .clock, .reset, .action(req.action), .left_column(req.left_column),
      .top_row(req.top_row), .rect_width(req.rect_width), .rect_height(req.rect_height),
      .image_byte(req.image_byte), .read_page(req.read_page), .read_column(req.read_column),
      .cmd, .stat, .rsp_data(data), .rsp_ignored(ign));

   // Hold response until taken
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.finish) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
   end
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.read_data = data;
   assign rsp.ignored   = ign;
endmodule

// ===== sv/pfb_checker.sv =====
`include "page_framebuffer_blit_engine_macros.svh"
module pfb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data,
   input logic       rsp_ignored
);
   // Handshake outputs are always known out of reset
   `PFB_ASSERT_IMPL(a_known_handshake, clock, reset, 1'b1, !$isunknown(req_ready) && !$isunknown(rsp_valid), "handshake unknown")
   // Stalled response stays offered
   `PFB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
   // Stalled response keeps its payload
   `PFB_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_read_data) && $stable(rsp_ignored), "stalled response changed")
   // One request in flight: no acceptance right after another
   `PFB_ASSERT_NEXT(a_req_spacing, clock, reset, req_valid && req_ready, !req_ready, "request accepted back to back")
endmodule

bind page_framebuffer_blit_engine pfb_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_read_data(rsp.read_data),
   .rsp_ignored(rsp.ignored));
